[rtl/flash_row_packet_assembler_macros.svh]
// assertion macros for the flash row packet assembler
// no dependencies; taken in by the top level with an include
`ifndef FLASH_ROW_PACKET_ASSEMBLER_MACROS_SVH
`define FLASH_ROW_PACKET_ASSEMBLER_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define FRPA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define FRPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRPA_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define FRPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/frpa_pkg.sv]
// shared types, constants and helper functions of the flash row packet assembler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frpa_pkg;

    localparam int ROW_BYTES      = 256;
    localparam int CHUNK_BYTES    = 30;
    localparam int WORD_BYTES     = 8;
    localparam int ROW_WORDS      = ROW_BYTES / WORD_BYTES;
    localparam int ROW_ADDR_W     = $clog2(ROW_BYTES);
    localparam int WORD_ADDR_W    = $clog2(ROW_WORDS);
    localparam int LANE_W         = $clog2(WORD_BYTES);
    localparam int CHUNK_W        = CHUNK_BYTES * 8;
    localparam int LAST_SEQ       = ROW_BYTES / CHUNK_BYTES;
    localparam int LAST_COUNT     = ROW_BYTES - LAST_SEQ * CHUNK_BYTES;
    localparam int PROG_STEPS     = 8;

    localparam logic [15:0] HDR_RESET   = 16'hffff;
    localparam logic [15:0] HDR_WELCOME = 16'hff00;
    localparam logic [15:0] ROWS_RESET  = 16'd1024;
    localparam logic [5:0]  PKT_LEN     = 6'd32;
    localparam logic [2:0]  PIPE_PROG   = 3'd1;
    localparam logic [2:0]  PIPE_SLAVE  = 3'd2;

    typedef logic [3:0] t_status;

    localparam t_status ST_CHUNK       = 4'd0;
    localparam t_status ST_WELCOME     = 4'd1;
    localparam t_status ST_ROW_WORD    = 4'd2;
    localparam t_status ST_DONE        = 4'd3;
    localparam t_status ST_NOT_WELCOME = 4'd4;
    localparam t_status ST_WRONG_ID    = 4'd5;
    localparam t_status ST_WRONG_SEQ   = 4'd6;
    localparam t_status ST_RESET       = 4'd7;
    localparam t_status ST_FORWARD     = 4'd8;
    localparam t_status ST_BAD_LENGTH  = 4'd9;
    localparam t_status ST_IGNORED     = 4'd10;

    // first store byte written by chunk number seq
    function automatic logic [ROW_ADDR_W-1:0] chunk_base(input logic [3:0] seq);
        return ROW_ADDR_W'(seq * CHUNK_BYTES);
    endfunction

    // bytes that chunk number seq writes; the last chunk only fills the tail
    function automatic logic [4:0] chunk_count(input logic [3:0] seq);
        return (seq == 4'(LAST_SEQ)) ? 5'(LAST_COUNT) : 5'(CHUNK_BYTES);
    endfunction

    // thermometer mask with prog low bits set
    function automatic logic [7:0] thermo_mask(input logic [3:0] prog);
        logic [7:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[i] = (4'(i) < prog);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/frpa_if.sv]
// valid/ready channel interfaces for packet items in and result items out
// depends on frpa_pkg
`timescale 1ns / 1ps
`default_nettype none

interface frpa_in_if;
    import frpa_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  pipe;
    logic [5:0]  payload_length;
    logic [63:0] bytes_0_to_7;
    logic [63:0] bytes_8_to_15;
    logic [63:0] bytes_16_to_23;
    logic [63:0] bytes_24_to_31;

    modport source (
        output valid, pipe, payload_length,
        output bytes_0_to_7, bytes_8_to_15, bytes_16_to_23, bytes_24_to_31,
        input  ready
    );
    modport sink (
        input  valid, pipe, payload_length,
        input  bytes_0_to_7, bytes_8_to_15, bytes_16_to_23, bytes_24_to_31,
        output ready
    );
endinterface

interface frpa_out_if;
    import frpa_pkg::*;

    logic        valid;
    logic        ready;
    t_status     status;
    logic        is_row_data;
    logic [15:0] row_number;
    logic [4:0]  word_index;
    logic [63:0] row_word;
    logic        last;
    logic [7:0]  progress_mask;
    logic [15:0] rows_done;

    modport source (
        output valid, status, is_row_data, row_number, word_index,
        output row_word, last, progress_mask, rows_done,
        input  ready
    );
    modport sink (
        input  valid, status, is_row_data, row_number, word_index,
        input  row_word, last, progress_mask, rows_done,
        output ready
    );
endinterface

`default_nettype wire

[rtl/flash_row_packet_assembler.sv]
// flash row packet assembler: session checks, row store and row word emission
// depends on frpa_pkg, frpa_if and flash_row_packet_assembler_macros.svh
//
//  port       dir   kind          carries
//  i_in       in    valid/ready   one 32-byte radio packet with pipe and length
//  o_out      out   valid/ready   one result item (status, row word, progress)
//  i_cfg_we   in    write strobe  device identifier write, data on i_cfg_data
//
// a packet that gives one result loads it into the output register; a chunk then
// writes its 30 bytes (16 for the ninth) into the row store, one byte a cycle
// the ninth chunk then runs the shared add/compare unit for progress
// and then 32 row words, one a cycle while the output does not stall, through the registered store read port
// reset is synchronous and needs no clearing pass; the store is never read
// before a full row was written. a stalled output holds the sequencer
`timescale 1ns / 1ps
`default_nettype none

module flash_row_packet_assembler (
    input  wire         i_clk,
    input  wire         i_rst_n,
    frpa_in_if.sink     i_in,
    frpa_out_if.source  o_out,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_data
);
    import frpa_pkg::*;

    `include "flash_row_packet_assembler_macros.svh"

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_PROG  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [31:0]            r_dev_id;
    logic                   r_await, n_await;
    logic [15:0]            r_start, n_start;
    logic [15:0]            r_total, n_total;
    logic [15:0]            r_exp_row, n_exp_row;
    logic [3:0]             r_exp_seq, n_exp_seq;
    logic [4:0]             r_cnt, n_cnt;
    logic [ROW_ADDR_W-1:0]  r_waddr, n_waddr;
    logic                   r_seq8, n_seq8;
    logic [2:0]             r_step, n_step;
    logic [3:0]             r_prog, n_prog;
    logic [19:0]            r_acc, n_acc;
    logic [WORD_ADDR_W:0]   r_iss, n_iss;
    logic                   r_rv, n_rv;
    logic                   r_ov, n_ov;

    logic [CHUNK_W-1:0]     r_chunk;
    logic [15:0]            r_row;
    logic [15:0]            r_diff;
    logic                   r_finished;
    logic [WORD_ADDR_W-1:0] r_rd_idx;
    logic [63:0]            r_rdata;
    logic [63:0]            r_row_mem [ROW_WORDS];

    t_status                r_o_status;
    logic                   r_o_is_row;
    logic [15:0]            r_o_row;
    logic [4:0]             r_o_widx;
    logic [63:0]            r_o_word;
    logic                   r_o_last;
    logic [7:0]             r_o_mask;
    logic [15:0]            r_o_done;

    logic                   in_acc;
    logic                   rd_issue;
    logic                   load_rd;
    logic                   single;
    t_status                single_status;
    logic [15:0]            single_row;
    logic                   load_chunk;
    logic                   sess_rst;
    logic [15:0]            hdr;
    logic [15:0]            pkt_start;
    logic [15:0]            pkt_total;
    logic [31:0]            pkt_id;
    logic [CHUNK_W-1:0]     pkt_chunk;
    logic                   chunk_bad;
    logic [19:0]            sum;
    logic [19:0]            diff8;

    assign hdr       = i_in.bytes_0_to_7[15:0];
    assign pkt_start = i_in.bytes_0_to_7[31:16];
    assign pkt_total = i_in.bytes_0_to_7[47:32];
    assign pkt_id    = {i_in.bytes_8_to_15[15:0], i_in.bytes_0_to_7[63:48]};
    assign pkt_chunk = {i_in.bytes_24_to_31, i_in.bytes_16_to_23,
                        i_in.bytes_8_to_15, i_in.bytes_0_to_7[63:16]};
    assign chunk_bad = ({6'd0, hdr[9:0]} != r_exp_row) ||
                       (hdr[15:10] != {2'b00, r_exp_seq}) ||
                       (r_exp_seq > 4'(LAST_SEQ));

    assign i_in.ready = (r_state == S_IDLE) && (!r_ov || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;

    // two-deep read pipe: store read register, then output register
    assign load_rd  = r_rv && (!r_ov || o_out.ready);
    assign rd_issue = (r_state == S_EMIT) && !r_iss[WORD_ADDR_W] && (!r_rv || load_rd);

    // shared add/compare unit: one multiple of total_rows per step against 8 * diff
    assign sum   = r_acc + {4'd0, r_total};
    assign diff8 = {1'b0, r_diff, 3'b000};

    always_comb begin
        n_state    = r_state;
        n_await    = r_await;
        n_start    = r_start;
        n_total    = r_total;
        n_exp_row  = r_exp_row;
        n_exp_seq  = r_exp_seq;
        n_cnt      = r_cnt;
        n_waddr    = r_waddr;
        n_seq8     = r_seq8;
        n_step     = r_step;
        n_prog     = r_prog;
        n_acc      = r_acc;
        n_iss      = r_iss;
        single        = 1'b0;
        single_status = ST_IGNORED;
        single_row    = '0;
        load_chunk    = 1'b0;
        sess_rst      = 1'b0;

        if (in_acc) begin
            single = 1'b1;
            if (i_in.payload_length != PKT_LEN) begin
                single_status = ST_BAD_LENGTH;
            end else if (hdr == HDR_RESET) begin
                sess_rst      = 1'b1;
                single_status = ST_RESET;
            end else if (i_in.pipe == PIPE_SLAVE) begin
                single_status = ST_FORWARD;
            end else if (i_in.pipe != PIPE_PROG) begin
                single_status = ST_IGNORED;
            end else if (r_await) begin
                if (hdr != HDR_WELCOME) begin
                    sess_rst      = 1'b1;
                    single_status = ST_NOT_WELCOME;
                end else if (pkt_id != r_dev_id) begin
                    sess_rst      = 1'b1;
                    single_status = ST_WRONG_ID;
                end else begin
                    n_start       = pkt_start;
                    n_exp_row     = pkt_start;
                    n_total       = pkt_total;
                    n_await       = 1'b0;
                    n_exp_seq     = '0;
                    single_status = ST_WELCOME;
                    single_row    = pkt_start;
                end
            end else if (chunk_bad) begin
                sess_rst      = 1'b1;
                single_status = ST_WRONG_SEQ;
            end else begin
                load_chunk = 1'b1;
                n_state    = S_WRITE;
                n_cnt      = chunk_count(r_exp_seq);
                n_waddr    = chunk_base(r_exp_seq);
                n_seq8     = (r_exp_seq == 4'(LAST_SEQ));
                if (r_exp_seq != 4'(LAST_SEQ)) begin
                    n_exp_seq     = r_exp_seq + 4'd1;
                    single_status = ST_CHUNK;
                    single_row    = r_exp_row;
                end else begin
                    single    = 1'b0;
                    n_exp_seq = '0;
                    n_exp_row = r_exp_row + 16'd1;
                end
            end
        end

        if (sess_rst) begin
            n_await   = 1'b1;
            n_start   = '0;
            n_total   = ROWS_RESET;
            n_exp_row = '0;
            n_exp_seq = '0;
        end

        case (r_state)
            S_WRITE: begin
                n_waddr = r_waddr + ROW_ADDR_W'(1);
                n_cnt   = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_state = r_seq8 ? S_PROG : S_IDLE;
                    n_acc   = '0;
                    n_prog  = '0;
                    n_step  = '0;
                end
            end
            S_PROG: begin
                if (sum <= diff8) begin
                    n_acc  = sum;
                    n_prog = r_prog + 4'd1;
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'(PROG_STEPS - 1)) begin
                    n_state = S_EMIT;
                    n_iss   = '0;
                end
            end
            S_EMIT: begin
                if (rd_issue) begin
                    n_iss = r_iss + (WORD_ADDR_W+1)'(1);
                end
                if (load_rd && (r_rd_idx == WORD_ADDR_W'(ROW_WORDS - 1))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (rd_issue) begin
            n_rv = 1'b1;
        end else if (load_rd) begin
            n_rv = 1'b0;
        end else begin
            n_rv = r_rv;
        end

        if ((in_acc && single) || load_rd) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dev_id  <= '0;
            r_await   <= 1'b1;
            r_start   <= '0;
            r_total   <= ROWS_RESET;
            r_exp_row <= '0;
            r_exp_seq <= '0;
            r_cnt     <= '0;
            r_waddr   <= '0;
            r_seq8    <= 1'b0;
            r_step    <= '0;
            r_prog    <= '0;
            r_acc     <= '0;
            r_iss     <= '0;
            r_rv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_dev_id <= i_cfg_data;
            end
            r_await   <= n_await;
            r_start   <= n_start;
            r_total   <= n_total;
            r_exp_row <= n_exp_row;
            r_exp_seq <= n_exp_seq;
            r_cnt     <= n_cnt;
            r_waddr   <= n_waddr;
            r_seq8    <= n_seq8;
            r_step    <= n_step;
            r_prog    <= n_prog;
            r_acc     <= n_acc;
            r_iss     <= n_iss;
            r_rv      <= n_rv;
            r_ov      <= n_ov;
        end
    end

    // chunk bytes shift out one per cycle into the store
    always_ff @(posedge i_clk) begin
        if (load_chunk) begin
            r_chunk <= pkt_chunk;
        end else if (r_state == S_WRITE) begin
            r_chunk <= {8'd0, r_chunk[CHUNK_W-1:8]};
        end
        if (load_chunk && n_seq8) begin
            r_row      <= r_exp_row;
            r_diff     <= r_exp_row - r_start;
            r_finished <= ({1'b0, r_exp_row + 16'd1} == ({1'b0, r_start} + {1'b0, r_total}));
        end
    end

    // row store: 32 words, one byte lane written a cycle, one word read a cycle while the read pipe is free
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_row_mem[r_waddr[ROW_ADDR_W-1:LANE_W]][{r_waddr[LANE_W-1:0], 3'b000} +: 8]
                <= r_chunk[7:0];
        end
        if (rd_issue) begin
            r_rdata  <= r_row_mem[r_iss[WORD_ADDR_W-1:0]];
            r_rd_idx <= r_iss[WORD_ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && single) begin
            r_o_status <= single_status;
            r_o_is_row <= 1'b0;
            r_o_row    <= single_row;
            r_o_widx   <= '0;
            r_o_word   <= '0;
            r_o_last   <= 1'b1;
            r_o_mask   <= '0;
            r_o_done   <= '0;
        end else if (load_rd) begin
            r_o_status <= ((r_rd_idx == WORD_ADDR_W'(ROW_WORDS - 1)) && r_finished)
                          ? ST_DONE : ST_ROW_WORD;
            r_o_is_row <= 1'b1;
            r_o_row    <= r_row;
            r_o_widx   <= r_rd_idx;
            r_o_word   <= r_rdata;
            r_o_last   <= (r_rd_idx == WORD_ADDR_W'(ROW_WORDS - 1));
            r_o_mask   <= thermo_mask(r_prog);
            r_o_done   <= r_diff + 16'd1;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.status        = r_o_status;
    assign o_out.is_row_data   = r_o_is_row;
    assign o_out.row_number    = r_o_row;
    assign o_out.word_index    = r_o_widx;
    assign o_out.row_word      = r_o_word;
    assign o_out.last          = r_o_last;
    assign o_out.progress_mask = r_o_mask;
    assign o_out.rows_done     = r_o_done;

    `FRPA_ASSERT_RST(a_row_word_in_emit, i_clk, i_rst_n, (r_rv |-> (r_state == S_EMIT)), "row word pending outside emission")
    `FRPA_ASSERT_RST(a_last_word_index, i_clk, i_rst_n, ((o_out.valid && o_out.is_row_data && o_out.last) |-> (o_out.word_index == 5'd31)), "last row word has wrong index")
    `FRPA_ASSERT_RST(a_prog_range, i_clk, i_rst_n, (r_prog <= 4'd8), "progress count beyond eight")
    `FRPA_ASSERT_RST(a_write_done_idle, i_clk, i_rst_n, (((r_state == S_WRITE) && (r_cnt == 5'd1) && !r_seq8) |=> (r_state == S_IDLE)), "chunk write did not return to idle")

endmodule

`default_nettype wire

[dv/tb_flash_row_packet_assembler.sv]
// testbench for flash_row_packet_assembler: random radio packets and row sessions,
// results checked in order against a predictor kept in step with accepted items
// depends on frpa_pkg, frpa_if and the rtl of the block
`timescale 1ns / 1ps

module tb_flash_row_packet_assembler;
    import frpa_pkg::*;

    localparam logic [2:0] PIPE_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [2:0]   pipe;
        logic [5:0]   len;
        logic [255:0] data;
    } radio_pkt_t;

    typedef struct packed {
        t_status     status;
        logic        is_row_data;
        logic [15:0] row_number;
        logic [4:0]  word_index;
        logic [63:0] row_word;
        logic        last;
        logic [7:0]  progress_mask;
        logic [15:0] rows_done;
    } row_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    frpa_in_if  in_if ();
    frpa_out_if out_if ();

    flash_row_packet_assembler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    radio_pkt_t  pending_packets[$];
    row_result_t results_due[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_left;
    logic        hold_start;
    logic [31:0] cur_dev_id;
    int          random_items;

    // predictor state
    logic        want_welcome;
    logic [15:0] sess_start_row;
    logic [15:0] sess_total_rows;
    logic [15:0] next_row;
    logic [3:0]  next_seq;
    logic [7:0]  row_bytes [256];
    logic [31:0] device_id;

    always #5 i_clk = ~i_clk;

    function automatic void due(t_status st, logic [15:0] row, logic [4:0] idx,
                                logic [63:0] word, logic last, logic [7:0] mask,
                                logic [15:0] done);
        row_result_t r;
        r.status        = st;
        r.is_row_data   = (st == ST_ROW_WORD) || (st == ST_DONE);
        r.row_number    = row;
        r.word_index    = idx;
        r.row_word      = word;
        r.last          = last;
        r.progress_mask = mask;
        r.rows_done     = done;
        results_due.push_back(r);
    endfunction

    function automatic void session_clear();
        want_welcome    = 1'b1;
        sess_start_row  = '0;
        sess_total_rows = ROWS_RESET;
        next_row        = '0;
        next_seq        = '0;
    endfunction

    function automatic void assemble_packet(radio_pkt_t p);
        logic [15:0] hdr;
        logic [15:0] row;
        logic [15:0] diff;
        logic [63:0] word;
        logic        fin;
        logic [7:0]  mask;
        int unsigned prog;
        int unsigned base;
        int unsigned cnt;
        hdr = p.data[15:0];
        if (p.len != PKT_LEN) begin
            due(ST_BAD_LENGTH, '0, '0, '0, 1'b1, '0, '0);
            return;
        end
        if (hdr == HDR_RESET) begin
            session_clear();
            due(ST_RESET, '0, '0, '0, 1'b1, '0, '0);
            return;
        end
        if (p.pipe == PIPE_SLAVE) begin
            due(ST_FORWARD, '0, '0, '0, 1'b1, '0, '0);
            return;
        end
        if (p.pipe != PIPE_PROG) begin
            due(ST_IGNORED, '0, '0, '0, 1'b1, '0, '0);
            return;
        end
        if (want_welcome) begin
            if (hdr != HDR_WELCOME) begin
                session_clear();
                due(ST_NOT_WELCOME, '0, '0, '0, 1'b1, '0, '0);
                return;
            end
            sess_start_row  = p.data[31:16];
            next_row        = p.data[31:16];
            sess_total_rows = p.data[47:32];
            if (p.data[79:48] != device_id) begin
                session_clear();
                due(ST_WRONG_ID, '0, '0, '0, 1'b1, '0, '0);
                return;
            end
            want_welcome = 1'b0;
            next_seq     = '0;
            due(ST_WELCOME, sess_start_row, '0, '0, 1'b1, '0, '0);
            return;
        end
        // chunk: low ten header bits carry the row, top six the sequence
        if ({6'd0, hdr[9:0]} != next_row || {2'd0, next_seq} != hdr[15:10]
                || next_seq > 4'(LAST_SEQ)) begin
            session_clear();
            due(ST_WRONG_SEQ, '0, '0, '0, 1'b1, '0, '0);
            return;
        end
        base = next_seq * CHUNK_BYTES;
        cnt  = (next_seq == 4'(LAST_SEQ)) ? LAST_COUNT : CHUNK_BYTES;
        for (int i = 0; i < cnt; i++) begin
            row_bytes[(base + i) % ROW_BYTES] = p.data[8 * (2 + i) +: 8];
        end
        if (next_seq != 4'(LAST_SEQ)) begin
            next_seq = next_seq + 4'd1;
            due(ST_CHUNK, next_row, '0, '0, 1'b1, '0, '0);
            return;
        end
        row  = next_row;
        diff = row - sess_start_row;
        if (sess_total_rows == '0) begin
            prog = PROG_STEPS;
        end else begin
            prog = (32'(diff) * PROG_STEPS) / sess_total_rows;
            if (prog > PROG_STEPS) prog = PROG_STEPS;
        end
        mask     = 8'((9'd1 << prog) - 9'd1);
        next_seq = '0;
        next_row = row + 16'd1;
        fin      = ({1'b0, next_row} == 17'(sess_start_row) + 17'(sess_total_rows));
        for (int w = 0; w < ROW_WORDS; w++) begin
            for (int b = 0; b < WORD_BYTES; b++) begin
                word[8 * b +: 8] = row_bytes[w * WORD_BYTES + b];
            end
            due((w == ROW_WORDS - 1 && fin) ? ST_DONE : ST_ROW_WORD, row, 5'(w), word,
                w == ROW_WORDS - 1, mask, diff + 16'd1);
        end
    endfunction

    // predictor follows config writes and accepted items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            session_clear();
            device_id = '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                assemble_packet({in_if.pipe, in_if.payload_length, in_if.bytes_24_to_31,
                                 in_if.bytes_16_to_23, in_if.bytes_8_to_15,
                                 in_if.bytes_0_to_7});
            end
            if (i_cfg_we) device_id = i_cfg_data;
        end
    end

    // driver
    always @(posedge i_clk) begin
        radio_pkt_t p;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                p = pending_packets.pop_front();
                in_if.valid          <= 1'b1;
                in_if.pipe           <= p.pipe;
                in_if.payload_length <= p.len;
                in_if.bytes_0_to_7   <= p.data[63:0];
                in_if.bytes_8_to_15  <= p.data[127:64];
                in_if.bytes_16_to_23 <= p.data[191:128];
                in_if.bytes_24_to_31 <= p.data[255:192];
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_start) hold_left <= HOLD_CYCLES;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %0h, actual %0h", $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        row_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (results_due.size() == 0) begin
                $display("%0t unexpected item: expected none, actual status %0d",
                         $realtime, out_if.status);
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                check_field("status", 64'(want.status), 64'(out_if.status));
                check_field("is_row_data", 64'(want.is_row_data), 64'(out_if.is_row_data));
                check_field("row_number", 64'(want.row_number), 64'(out_if.row_number));
                check_field("word_index", 64'(want.word_index), 64'(out_if.word_index));
                check_field("row_word", want.row_word, out_if.row_word);
                check_field("last", 64'(want.last), 64'(out_if.last));
                check_field("progress_mask", 64'(want.progress_mask),
                            64'(out_if.progress_mask));
                check_field("rows_done", 64'(want.rows_done), 64'(out_if.rows_done));
            end
        end
    end

    function automatic logic [255:0] random_body();
        logic [255:0] d;
        for (int i = 0; i < 8; i++) d[32 * i +: 32] = $urandom;
        return d;
    endfunction

    function automatic void send(logic [2:0] pipe, logic [5:0] len, logic [15:0] hdr);
        radio_pkt_t p;
        p.pipe       = pipe;
        p.len        = len;
        p.data       = random_body();
        p.data[15:0] = hdr;
        pending_packets.push_back(p);
        random_items++;
    endfunction

    function automatic void send_welcome(logic [15:0] start, logic [15:0] total,
                                         logic [31:0] id);
        radio_pkt_t p;
        p.pipe        = PIPE_PROG;
        p.len         = PKT_LEN;
        p.data        = random_body();
        p.data[15:0]  = HDR_WELCOME;
        p.data[31:16] = start;
        p.data[47:32] = total;
        p.data[79:48] = id;
        pending_packets.push_back(p);
        random_items++;
    endfunction

    function automatic void send_chunk(logic [15:0] row, logic [3:0] seq, bit corrupt);
        logic [15:0] hdr;
        hdr = {2'd0, seq, row[9:0]};
        if (corrupt) hdr[$urandom_range(15)] ^= 1'b1;
        send(PIPE_PROG, PKT_LEN, hdr);
    endfunction

    function automatic logic [2:0] unused_pipe();
        logic [2:0] p;
        do p = 3'($urandom_range(7)); while (p == PIPE_PROG || p == PIPE_SLAVE);
        return p;
    endfunction

    function automatic void send_noise();
        case ($urandom_range(4))
            0: send(3'($urandom), 6'($urandom_range(31)), 16'($urandom));
            1: send(PIPE_SLAVE, PKT_LEN, 16'($urandom));
            2: send(unused_pipe(), PKT_LEN, 16'($urandom));
            3: send(3'($urandom), PKT_LEN, HDR_RESET);
            default: send(PIPE_PROG, PKT_LEN, 16'($urandom));
        endcase
    endfunction

    // noise that leaves the session untouched
    function automatic void send_harmless();
        case ($urandom_range(2))
            0: send(3'($urandom), 6'($urandom_range(31)), 16'($urandom));
            1: send(PIPE_SLAVE, PKT_LEN, 16'($urandom_range(16'hfffe)));
            default: send(unused_pipe(), PKT_LEN, 16'($urandom_range(16'hfffe)));
        endcase
    endfunction

    function automatic void send_session();
        int          rows;
        logic [15:0] start;
        logic [15:0] total;
        logic [31:0] id;
        rows = $urandom_range(1, 3);
        case ($urandom_range(9))
            0, 1, 2, 3: total = 16'(rows);
            4, 5:       total = 16'($urandom_range(rows, 20));
            6:          total = 16'($urandom_range(0, rows - 1));
            7:          total = 16'hffff;
            default:    total = 16'($urandom);
        endcase
        case ($urandom_range(19))
            0:       start = 16'($urandom);
            1:       start = 16'd1023;
            default: start = 16'($urandom_range(1023 - rows));
        endcase
        id = ($urandom_range(9) == 0) ? $urandom : cur_dev_id;
        if ($urandom_range(9) < 7) send(3'($urandom), PKT_LEN, HDR_RESET);
        send_welcome(start, total, id);
        for (int r = 0; r < rows; r++) begin
            for (int s = 0; s <= LAST_SEQ; s++) begin
                if ($urandom_range(99) < 8) send_harmless();
                send_chunk(start + 16'(r), 4'(s), $urandom_range(99) < 2);
            end
        end
    endfunction

    task automatic drain(input int tail);
        while (pending_packets.size() != 0 || in_if.valid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_device_id(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_dev_id = value;
    endtask

    initial begin
        #5_000_000;
        $display("[flash_row_packet_assembler] ERROR");
        $finish;
    end

    initial begin
        logic [31:0] phase_ids [4];
        int          phase_send [4];
        int          phase_stall [4];
        int          goal;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = '0;
        hold_start           = 1'b0;
        hold_left            = 0;
        send_idle_pct        = 0;
        stall_pct            = 0;
        cur_dev_id           = '0;
        mismatch_count       = 0;
        random_items         = 0;
        in_if.valid          = 1'b0;
        in_if.pipe           = '0;
        in_if.payload_length = '0;
        in_if.bytes_0_to_7   = '0;
        in_if.bytes_8_to_15  = '0;
        in_if.bytes_16_to_23 = '0;
        in_if.bytes_24_to_31 = '0;
        out_if.ready         = 1'b0;
        phase_ids   = '{32'hffff_ffff, $urandom, 32'h0, $urandom};
        phase_send  = '{0, 45, 0, 24};
        phase_stall = '{0, 0, 45, 24};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: device id still at its reset value
        send(PIPE_PROG, 6'd0, 16'h0000);
        send(PIPE_PROG, PKT_LEN, HDR_RESET);
        send(PIPE_SLAVE, PKT_LEN, 16'h1234);
        send(PIPE_UNUSED, PKT_LEN, 16'h4321);
        send(PIPE_PROG, PKT_LEN, 16'h1234);
        send_welcome(16'd0, 16'd5, 32'h0000_0001);
        // zero row count: progress saturates at once
        send_welcome(16'd0, 16'd0, 32'h0);
        for (int s = 0; s <= LAST_SEQ; s++) send_chunk(16'd0, 4'(s), 1'b0);
        send_chunk(16'd1, 4'd3, 1'b0);
        // one-row session on the highest row that chunks can reach
        send_welcome(16'd1023, 16'd1, 32'h0);
        for (int s = 0; s <= LAST_SEQ; s++) send_chunk(16'd1023, 4'(s), 1'b0);
        drain(40);

        random_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_device_id(phase_ids[ph]);
            send_idle_pct = phase_send[ph];
            stall_pct     = phase_stall[ph];
            goal          = 75 * (ph + 1);
            while (random_items < goal) begin
                if ($urandom_range(3) == 0) begin
                    repeat ($urandom_range(1, 3)) send_noise();
                end else begin
                    send_session();
                end
            end
            // receiver holds off while the queue of items is still full
            if (ph == 0) begin
                @(posedge i_clk);
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            drain(40);
        end

        drain(64);
        if (mismatch_count == 0) begin
            $display("[flash_row_packet_assembler] OK");
        end else begin
            $display("[flash_row_packet_assembler] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/frpa_pkg.sv
rtl/frpa_if.sv
rtl/flash_row_packet_assembler.sv
dv/tb_flash_row_packet_assembler.sv
